>>> src/fvl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fvl_pkg: shared types and constants of the formation velocity law
// Field widths, register indexes, register file layout and the item that
// travels from the front end through the queue to the divider back end.
// ----------------------------------------------------------------------------
package fvl_pkg;

	localparam int POS_W         = 24;
	localparam int DIFF_W        = POS_W + 1;
	localparam int SQ_W          = 2 * DIFF_W;
	localparam int ERR_W         = 36;
	localparam int TGT_W         = 32;
	localparam int GAIN_W        = 16;
	localparam int DET_W         = 2 * DIFF_W;
	localparam int NUM_W         = DIFF_W + ERR_W;
	localparam int VEL_W         = 24;
	localparam int QB            = VEL_W - 1;
	localparam int DIV_LAT       = QB + 3;
	localparam int FRAC_BITS_DEF = 16;
	localparam int SING2_BOUND   = 100;
	localparam int SING3_BOUND   = 1000;
	localparam int QUEUE_DEPTH   = 4;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 32;

	localparam logic signed [ERR_W-1:0] ERR_LIM = 36'sd34359738367;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ANCHOR_X         = 3'd0,
		CFG_ANCHOR_Y         = 3'd1,
		CFG_TARGET_SQ_12     = 3'd2,
		CFG_TARGET_SQ_13     = 3'd3,
		CFG_TARGET_SQ_23     = 3'd4,
		CFG_GAIN_NEAR        = 3'd5,
		CFG_GAIN_FAR         = 3'd6,
		CFG_SWITCH_THRESHOLD = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic signed [POS_W-1:0] anchor_x;
		logic signed [POS_W-1:0] anchor_y;
		logic [TGT_W-1:0]        target_sq_12;
		logic [TGT_W-1:0]        target_sq_13;
		logic [TGT_W-1:0]        target_sq_23;
		logic [GAIN_W-1:0]       gain_near;
		logic [GAIN_W-1:0]       gain_far;
		logic [TGT_W-1:0]        switch_threshold;
	} cfg_t;

	typedef struct packed {
		logic signed [NUM_W-1:0] n0_2;
		logic signed [NUM_W-1:0] n1_2;
		logic signed [NUM_W-1:0] n0_3;
		logic signed [NUM_W-1:0] n1_3;
		logic signed [DET_W-1:0] det2;
		logic signed [DET_W-1:0] det3;
		logic [GAIN_W-1:0]       k;
		logic                    near;
		logic                    sing2;
		logic                    sing3;
	} item_t;

endpackage

`default_nettype wire

>>> src/fvl_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fvl_if: channel interfaces
// Position request channel, velocity result channel and register write channel.
// ----------------------------------------------------------------------------
interface fvl_pos_if;
	logic                             valid;
	logic                             ready;
	logic signed [fvl_pkg::POS_W-1:0] pos2_x;
	logic signed [fvl_pkg::POS_W-1:0] pos2_y;
	logic signed [fvl_pkg::POS_W-1:0] pos3_x;
	logic signed [fvl_pkg::POS_W-1:0] pos3_y;

	modport source (output valid, pos2_x, pos2_y, pos3_x, pos3_y, input ready);
	modport sink (input valid, pos2_x, pos2_y, pos3_x, pos3_y, output ready);
endinterface

interface fvl_vel_if;
	logic                             valid;
	logic                             ready;
	logic signed [fvl_pkg::VEL_W-1:0] vel2_x;
	logic signed [fvl_pkg::VEL_W-1:0] vel2_y;
	logic signed [fvl_pkg::VEL_W-1:0] vel3_x;
	logic signed [fvl_pkg::VEL_W-1:0] vel3_y;
	logic                             near_gain_used;
	logic                             singular2;
	logic                             singular3;

	modport source (output valid, vel2_x, vel2_y, vel3_x, vel3_y, near_gain_used,
		singular2, singular3, input ready);
	modport sink (input valid, vel2_x, vel2_y, vel3_x, vel3_y, near_gain_used,
		singular2, singular3, output ready);
endinterface

interface fvl_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [fvl_pkg::CFG_IDX_W-1:0]       index;
	logic [fvl_pkg::CFG_DATA_W-1:0]      data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/formation_velocity_law_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// formation_velocity_law_top: distance-based formation velocity law
// Register file, six stage front end, item queue and divider back end.
// ----------------------------------------------------------------------------
// A request passes 6 front stages, the item queue and 26 back stages incl.
// the result register. Throughput: one request per cycle while the result
// channel does not stall, set by the 23 stage restoring dividers.
// Reset clears the pipeline valids and queue count and loads register defaults.
// ----------------------------------------------------------------------------
module formation_velocity_law_top #(
	parameter int FRAC_BITS = fvl_pkg::FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	fvl_pos_if.sink    pos,
	fvl_vel_if.source  vel,
	fvl_cfg_if.sink    cfg
);

	fvl_pkg::cfg_t  cfg_q;
	fvl_pkg::item_t f_item, q_item;
	logic           push, pop, full, empty;

	assign cfg.ready = 1'b1;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.anchor_x         <= -24'sd196608;
			cfg_q.anchor_y         <= 24'sd262144;
			cfg_q.target_sq_12     <= 32'd262144;
			cfg_q.target_sq_13     <= 32'd262144;
			cfg_q.target_sq_23     <= 32'd786432;
			cfg_q.gain_near        <= 16'd655;
			cfg_q.gain_far         <= 16'd2621;
			cfg_q.switch_threshold <= 32'd327680;
		end else if (cfg.valid) begin
			case (fvl_pkg::cfg_idx_t'(cfg.index))
				fvl_pkg::CFG_ANCHOR_X: begin
					cfg_q.anchor_x <= cfg.data[fvl_pkg::POS_W-1:0];
				end
				fvl_pkg::CFG_ANCHOR_Y: begin
					cfg_q.anchor_y <= cfg.data[fvl_pkg::POS_W-1:0];
				end
				fvl_pkg::CFG_TARGET_SQ_12: begin
					cfg_q.target_sq_12 <= cfg.data[fvl_pkg::TGT_W-1:0];
				end
				fvl_pkg::CFG_TARGET_SQ_13: begin
					cfg_q.target_sq_13 <= cfg.data[fvl_pkg::TGT_W-1:0];
				end
				fvl_pkg::CFG_TARGET_SQ_23: begin
					cfg_q.target_sq_23 <= cfg.data[fvl_pkg::TGT_W-1:0];
				end
				fvl_pkg::CFG_GAIN_NEAR: begin
					cfg_q.gain_near <= cfg.data[fvl_pkg::GAIN_W-1:0];
				end
				fvl_pkg::CFG_GAIN_FAR: begin
					cfg_q.gain_far <= cfg.data[fvl_pkg::GAIN_W-1:0];
				end
				fvl_pkg::CFG_SWITCH_THRESHOLD: begin
					cfg_q.switch_threshold <= cfg.data[fvl_pkg::TGT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// front end
	fvl_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .pos(pos), .cfg(cfg_q),
		.full(full), .push(push), .item(f_item)
	);

	// item queue
	fvl_queue #(.DEPTH(fvl_pkg::QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .din(f_item),
		.pop(pop), .dout(q_item), .full(full), .empty(empty)
	);

	// back end
	fvl_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .item(q_item), .empty(empty),
		.pop(pop), .vel(vel)
	);

endmodule

`default_nettype wire

>>> src/fvl_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fvl_front: error, gain and numerator front end
// Six stage pipeline: relative positions, products, squared distances and
// determinants, errors and singular flags, numerator products, numerators
// and gain selection. Stalls as a whole while the queue and stage 6 are full.
// ----------------------------------------------------------------------------
module fvl_front #(
	parameter int FRAC_BITS = fvl_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	fvl_pos_if.sink        pos,
	input  fvl_pkg::cfg_t  cfg,
	input  logic           full,
	output logic           push,
	output fvl_pkg::item_t item
);

	localparam int NST    = 6;
	localparam int DW     = fvl_pkg::DIFF_W;
	localparam int SW     = fvl_pkg::SQ_W;
	localparam int EW     = fvl_pkg::ERR_W;
	localparam int ESUB_W = SW + 2;
	localparam int BND_W  = 64;
	localparam int NW     = fvl_pkg::NUM_W;
	localparam int TW     = fvl_pkg::TGT_W;
	localparam int PAD_W  = ESUB_W - TW;
	localparam logic signed [ESUB_W-1:0] LIM_W = ESUB_W'(fvl_pkg::ERR_LIM);
	localparam logic [BND_W-1:0] ONE_SQ = BND_W'(1) << (2 * FRAC_BITS);

	logic           adv;
	logic [NST:1]   vld_q;

	// stage 1
	logic signed [DW-1:0] u2x_s1, u2y_s1, u3x_s1, u3y_s1, wx_s1, wy_s1;
	// stage 2
	logic signed [SW-1:0] q2x_s2, q2y_s2, q3x_s2, q3y_s2, qwx_s2, qwy_s2;
	logic signed [SW-1:0] pa_s2, pb_s2, pc_s2, pd_s2;
	logic signed [DW-1:0] u2x_s2, u2y_s2, u3x_s2, u3y_s2, wx_s2, wy_s2;
	// stage 3
	logic [SW-1:0]                       s12_s3, s13_s3, s23_s3;
	logic signed [fvl_pkg::DET_W-1:0]    det2_s3, det3_s3;
	logic signed [DW-1:0] u2x_s3, u2y_s3, u3x_s3, u3y_s3, wx_s3, wy_s3;
	// stage 4
	logic signed [EW-1:0]                e12_s4, e13_s4, e23_s4;
	logic signed [fvl_pkg::DET_W-1:0]    det2_s4, det3_s4;
	logic                                sing2_s4, sing3_s4;
	logic signed [DW-1:0] u2x_s4, u2y_s4, u3x_s4, u3y_s4, wx_s4, wy_s4;
	// stage 5
	logic signed [NW-1:0] ma_s5, mb_s5, mc_s5, md_s5, me_s5, mf_s5, mg_s5, mh_s5;
	logic [EW-1:0]                       ae12_s5, ae13_s5, ae23_s5;
	logic signed [fvl_pkg::DET_W-1:0]    det2_s5, det3_s5;
	logic                                sing2_s5, sing3_s5;
	// stage 6
	fvl_pkg::item_t item_s6;

	logic signed [ESUB_W-1:0] d12, d13, d23;
	logic [fvl_pkg::DET_W-1:0] adet2, adet3;
	logic [EW-1:0] mn;
	logic          near;

	// saturate a raw error to the error range
	function automatic logic signed [EW-1:0] sat_err(input logic signed [ESUB_W-1:0] v);
		logic signed [ESUB_W-1:0] r;
		r = v;
		if (v > LIM_W) r = LIM_W;
		if (v < -LIM_W) r = -LIM_W;
		return EW'(r);
	endfunction

	// magnitude of an error
	function automatic logic [EW-1:0] abs_err(input logic signed [EW-1:0] v);
		return v[EW-1] ? $unsigned(-v) : $unsigned(v);
	endfunction

	// pipeline advance and queue push
	assign adv       = !vld_q[NST] || !full;
	assign pos.ready = adv;
	assign push      = vld_q[NST] && !full;
	assign item      = item_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-1:1], pos.valid};
		end
	end

	// squared-distance errors, determinant magnitudes
	always_comb begin
		d12 = $signed({2'b00, s12_s3 >> FRAC_BITS}) - $signed({{PAD_W{1'b0}}, cfg.target_sq_12});
		d13 = $signed({2'b00, s13_s3 >> FRAC_BITS}) - $signed({{PAD_W{1'b0}}, cfg.target_sq_13});
		d23 = $signed({2'b00, s23_s3 >> FRAC_BITS}) - $signed({{PAD_W{1'b0}}, cfg.target_sq_23});
		adet2 = det2_s3[fvl_pkg::DET_W-1] ? $unsigned(-det2_s3) : $unsigned(det2_s3);
		adet3 = det3_s3[fvl_pkg::DET_W-1] ? $unsigned(-det3_s3) : $unsigned(det3_s3);
	end

	// smallest error magnitude and gain selection
	always_comb begin
		mn = ae12_s5;
		if (ae13_s5 < mn) mn = ae13_s5;
		if (ae23_s5 < mn) mn = ae23_s5;
		near = mn < EW'(cfg.switch_threshold);
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (adv) begin
			u2x_s1 <= {pos.pos2_x[fvl_pkg::POS_W-1], pos.pos2_x}
				- {cfg.anchor_x[fvl_pkg::POS_W-1], cfg.anchor_x};
			u2y_s1 <= {pos.pos2_y[fvl_pkg::POS_W-1], pos.pos2_y}
				- {cfg.anchor_y[fvl_pkg::POS_W-1], cfg.anchor_y};
			u3x_s1 <= {pos.pos3_x[fvl_pkg::POS_W-1], pos.pos3_x}
				- {cfg.anchor_x[fvl_pkg::POS_W-1], cfg.anchor_x};
			u3y_s1 <= {pos.pos3_y[fvl_pkg::POS_W-1], pos.pos3_y}
				- {cfg.anchor_y[fvl_pkg::POS_W-1], cfg.anchor_y};
			wx_s1  <= {pos.pos2_x[fvl_pkg::POS_W-1], pos.pos2_x}
				- {pos.pos3_x[fvl_pkg::POS_W-1], pos.pos3_x};
			wy_s1  <= {pos.pos2_y[fvl_pkg::POS_W-1], pos.pos2_y}
				- {pos.pos3_y[fvl_pkg::POS_W-1], pos.pos3_y};

			q2x_s2 <= u2x_s1 * u2x_s1;
			q2y_s2 <= u2y_s1 * u2y_s1;
			q3x_s2 <= u3x_s1 * u3x_s1;
			q3y_s2 <= u3y_s1 * u3y_s1;
			qwx_s2 <= wx_s1 * wx_s1;
			qwy_s2 <= wy_s1 * wy_s1;
			pa_s2  <= u2x_s1 * wy_s1;
			pb_s2  <= u2y_s1 * wx_s1;
			pc_s2  <= u3x_s1 * wy_s1;
			pd_s2  <= u3y_s1 * wx_s1;
			u2x_s2 <= u2x_s1; u2y_s2 <= u2y_s1; u3x_s2 <= u3x_s1;
			u3y_s2 <= u3y_s1; wx_s2 <= wx_s1; wy_s2 <= wy_s1;

			s12_s3  <= $unsigned(q2x_s2) + $unsigned(q2y_s2);
			s13_s3  <= $unsigned(q3x_s2) + $unsigned(q3y_s2);
			s23_s3  <= $unsigned(qwx_s2) + $unsigned(qwy_s2);
			det2_s3 <= pa_s2 - pb_s2;
			det3_s3 <= pd_s2 - pc_s2;
			u2x_s3 <= u2x_s2; u2y_s3 <= u2y_s2; u3x_s3 <= u3x_s2;
			u3y_s3 <= u3y_s2; wx_s3 <= wx_s2; wy_s3 <= wy_s2;

			e12_s4   <= sat_err(d12);
			e13_s4   <= sat_err(d13);
			e23_s4   <= sat_err(d23);
			det2_s4  <= det2_s3;
			det3_s4  <= det3_s3;
			sing2_s4 <= (BND_W'(adet2) * BND_W'(fvl_pkg::SING2_BOUND)) < ONE_SQ;
			sing3_s4 <= (BND_W'(adet3) * BND_W'(fvl_pkg::SING3_BOUND)) < ONE_SQ;
			u2x_s4 <= u2x_s3; u2y_s4 <= u2y_s3; u3x_s4 <= u3x_s3;
			u3y_s4 <= u3y_s3; wx_s4 <= wx_s3; wy_s4 <= wy_s3;

			ma_s5 <= wy_s4 * e12_s4;
			mb_s5 <= u2y_s4 * e23_s4;
			mc_s5 <= u2x_s4 * e23_s4;
			md_s5 <= wx_s4 * e12_s4;
			me_s5 <= wy_s4 * e13_s4;
			mf_s5 <= u3y_s4 * e23_s4;
			mg_s5 <= u3x_s4 * e23_s4;
			mh_s5 <= wx_s4 * e13_s4;
			ae12_s5  <= abs_err(e12_s4);
			ae13_s5  <= abs_err(e13_s4);
			ae23_s5  <= abs_err(e23_s4);
			det2_s5  <= det2_s4;
			det3_s5  <= det3_s4;
			sing2_s5 <= sing2_s4;
			sing3_s5 <= sing3_s4;

			item_s6.n0_2  <= ma_s5 - mb_s5;
			item_s6.n1_2  <= mc_s5 - md_s5;
			item_s6.n0_3  <= -me_s5 - mf_s5;
			item_s6.n1_3  <= mg_s5 + mh_s5;
			item_s6.det2  <= det2_s5;
			item_s6.det3  <= det3_s5;
			item_s6.k     <= near ? cfg.gain_near : cfg.gain_far;
			item_s6.near  <= near;
			item_s6.sing2 <= sing2_s5;
			item_s6.sing3 <= sing3_s5;
		end
	end

endmodule

`default_nettype wire

>>> src/fvl_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fvl_queue: item queue between front end and back end
// Small register queue; full and empty come from the registered count only.
// ----------------------------------------------------------------------------
module fvl_queue #(
	parameter int DEPTH = fvl_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fvl_pkg::item_t din,
	input  logic           pop,
	output fvl_pkg::item_t dout,
	output logic           full,
	output logic           empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	fvl_pkg::item_t  mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign full  = cnt_q == CW'(DEPTH);
	assign empty = cnt_q == '0;
	assign dout  = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// entry write
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// queue checks
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("pop from empty queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(DEPTH))
		else $error("queue count out of range");
	a_cnt_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count did not grow on push");

endmodule

`default_nettype wire

>>> src/fvl_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fvl_div: one velocity component
// Gain product, scaling and overflow test, then a pipelined restoring divider
// with one quotient bit per stage, then sign and saturation.
// ----------------------------------------------------------------------------
module fvl_div #(
	parameter int FRAC_BITS = fvl_pkg::FRAC_BITS_DEF,
	parameter int SH        = 1
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [fvl_pkg::NUM_W-1:0]   n,
	input  logic signed [fvl_pkg::DET_W-1:0]   det,
	input  logic [fvl_pkg::GAIN_W-1:0]         k,
	output logic signed [fvl_pkg::VEL_W-1:0]   q
);

	localparam int NW = fvl_pkg::NUM_W;
	localparam int DW = fvl_pkg::DET_W;
	localparam int QB = fvl_pkg::QB;
	localparam int VW = fvl_pkg::VEL_W;
	localparam int PW = NW + fvl_pkg::GAIN_W;
	localparam int WW = PW + FRAC_BITS;
	localparam int XW = WW - fvl_pkg::GAIN_W - SH;
	localparam int ZW = (XW > DW + QB) ? XW : DW + QB;
	localparam logic [VW-1:0] LIM_NEG = VW'(1) << QB;
	localparam logic [VW-1:0] LIM_POS = (VW'(1) << QB) - 1'b1;

	logic [NW-1:0]  nmag;
	logic [PW-1:0]  prod_s1;
	logic [DW-1:0]  d_s1;
	logic           zero_s1, neg_s1, dz_s1;

	logic [WW-1:0]  wide;
	logic [XW-1:0]  x;
	logic [ZW-1:0]  xe;
	logic           ovf;

	logic [DW-1:0]  rem_q [QB+1];
	logic [DW-1:0]  d_q   [QB+1];
	logic [QB-1:0]  xlo_q [QB+1];
	logic [QB-1:0]  qb_q  [QB+1];
	logic [QB:0]    sat_q, zero_q, neg_q;

	logic [DW-1:0]  nrem [1:QB];
	logic [QB-1:0]  nqb  [1:QB];
	logic [DW:0]    t    [1:QB];
	logic [VW-1:0]  qmag, res;

	// magnitude of the numerator for the gain product
	always_comb begin
		nmag = n[NW-1] ? $unsigned(-n) : $unsigned(n);
	end

	// scaling and quotient overflow test
	always_comb begin
		wide = {prod_s1, {FRAC_BITS{1'b0}}};
		x    = wide[WW-1:fvl_pkg::GAIN_W+SH];
		xe   = ZW'(x);
		ovf  = xe >= (ZW'(d_s1) << QB);
	end

	// one restoring step per stage
	always_comb begin
		for (int j = 1; j <= QB; j++) begin
			t[j] = {rem_q[j-1], xlo_q[j-1][QB-j]};
			if (t[j] >= {1'b0, d_q[j-1]}) begin
				nrem[j] = DW'(t[j] - {1'b0, d_q[j-1]});
				nqb[j]  = {qb_q[j-1][QB-2:0], 1'b1};
			end else begin
				nrem[j] = t[j][DW-1:0];
				nqb[j]  = {qb_q[j-1][QB-2:0], 1'b0};
			end
		end
	end

	// saturation and sign
	always_comb begin
		if (sat_q[QB]) begin
			qmag = neg_q[QB] ? LIM_NEG : LIM_POS;
		end else begin
			qmag = {1'b0, qb_q[QB]};
		end
		if (zero_q[QB]) begin
			res = '0;
		end else begin
			res = neg_q[QB] ? -qmag : qmag;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PW'(nmag) * PW'(k);
			d_s1    <= det[DW-1] ? $unsigned(-det) : $unsigned(det);
			zero_s1 <= (n == '0) || (k == '0);
			dz_s1   <= det == '0;
			neg_s1  <= (det == '0) ? (!n[NW-1] && n != '0) : (n[NW-1] == det[DW-1]);

			rem_q[0]  <= xe[DW+QB-1:QB];
			xlo_q[0]  <= xe[QB-1:0];
			d_q[0]    <= d_s1;
			qb_q[0]   <= '0;
			sat_q[0]  <= dz_s1 || ovf;
			zero_q[0] <= zero_s1;
			neg_q[0]  <= neg_s1;

			for (int j = 1; j <= QB; j++) begin
				rem_q[j]  <= nrem[j];
				xlo_q[j]  <= xlo_q[j-1];
				d_q[j]    <= d_q[j-1];
				qb_q[j]   <= nqb[j];
				sat_q[j]  <= sat_q[j-1];
				zero_q[j] <= zero_q[j-1];
				neg_q[j]  <= neg_q[j-1];
			end

			q <= res;
		end
	end

endmodule

`default_nettype wire

>>> src/fvl_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fvl_back: divider back end
// Takes items from the queue into four component dividers; the last divider
// stage is the result register. Stalls as a whole on result backpressure.
// ----------------------------------------------------------------------------
module fvl_back #(
	parameter int FRAC_BITS = fvl_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  fvl_pkg::item_t item,
	input  logic           empty,
	output logic           pop,
	fvl_vel_if.source      vel
);

	localparam int LAT = fvl_pkg::DIV_LAT;

	logic           adv;
	logic [LAT-1:0] vld_q;
	logic [LAT-1:0] near_q, sing2_q, sing3_q;

	assign adv = !vld_q[LAT-1] || vel.ready;
	assign pop = adv && !empty;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], pop};
		end
	end

	// flags travel alongside the dividers
	always_ff @(posedge clk) begin
		if (adv) begin
			near_q  <= {near_q[LAT-2:0], item.near};
			sing2_q <= {sing2_q[LAT-2:0], item.sing2};
			sing3_q <= {sing3_q[LAT-2:0], item.sing3};
		end
	end

	// component dividers
	fvl_div #(.FRAC_BITS(FRAC_BITS), .SH(1)) u_div2x (
		.clk(clk), .en(adv), .n(item.n0_2), .det(item.det2), .k(item.k), .q(vel.vel2_x)
	);
	fvl_div #(.FRAC_BITS(FRAC_BITS), .SH(2)) u_div2y (
		.clk(clk), .en(adv), .n(item.n1_2), .det(item.det2), .k(item.k), .q(vel.vel2_y)
	);
	fvl_div #(.FRAC_BITS(FRAC_BITS), .SH(1)) u_div3x (
		.clk(clk), .en(adv), .n(item.n0_3), .det(item.det3), .k(item.k), .q(vel.vel3_x)
	);
	fvl_div #(.FRAC_BITS(FRAC_BITS), .SH(2)) u_div3y (
		.clk(clk), .en(adv), .n(item.n1_3), .det(item.det3), .k(item.k), .q(vel.vel3_y)
	);

	// result channel
	assign vel.valid          = vld_q[LAT-1];
	assign vel.near_gain_used = near_q[LAT-1];
	assign vel.singular2      = sing2_q[LAT-1];
	assign vel.singular3      = sing3_q[LAT-1];

endmodule

`default_nettype wire

>>> tb/sv/formation_velocity_law_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// formation_velocity_law_top_tb: self-checking bench of the formation law
// Drives position requests under several idle and stall mixes and register
// settings, predicts each velocity result in a scoreboard class and checks
// every result field in order against the oldest prediction.
// ----------------------------------------------------------------------------
module formation_velocity_law_top_tb;

	typedef struct {
		logic signed [fvl_pkg::VEL_W-1:0] vel2_x;
		logic signed [fvl_pkg::VEL_W-1:0] vel2_y;
		logic signed [fvl_pkg::VEL_W-1:0] vel3_x;
		logic signed [fvl_pkg::VEL_W-1:0] vel3_y;
		logic                             near;
		logic                             sing2;
		logic                             sing3;
	} vel_rec_t;

	// predictor of the velocity law plus the queue of predicted results
	class formation_scoreboard;
		logic signed [fvl_pkg::POS_W-1:0] anc_x, anc_y;
		logic [fvl_pkg::TGT_W-1:0]        tgt12, tgt13, tgt23, thr;
		logic [fvl_pkg::GAIN_W-1:0]       k_near, k_far;
		vel_rec_t                         pending[$];
		int                               fails;

		function new();
			anc_x  = -24'sd196608;
			anc_y  = 24'sd262144;
			tgt12  = 262144;
			tgt13  = 262144;
			tgt23  = 786432;
			k_near = 655;
			k_far  = 2621;
			thr    = 327680;
			fails  = 0;
		endfunction

		function void write_reg(fvl_pkg::cfg_idx_t idx, logic [fvl_pkg::CFG_DATA_W-1:0] d);
			case (idx)
				fvl_pkg::CFG_ANCHOR_X:         anc_x = d[fvl_pkg::POS_W-1:0];
				fvl_pkg::CFG_ANCHOR_Y:         anc_y = d[fvl_pkg::POS_W-1:0];
				fvl_pkg::CFG_TARGET_SQ_12:     tgt12 = d;
				fvl_pkg::CFG_TARGET_SQ_13:     tgt13 = d;
				fvl_pkg::CFG_TARGET_SQ_23:     tgt23 = d;
				fvl_pkg::CFG_GAIN_NEAR:        k_near = d[fvl_pkg::GAIN_W-1:0];
				fvl_pkg::CFG_GAIN_FAR:         k_far = d[fvl_pkg::GAIN_W-1:0];
				fvl_pkg::CFG_SWITCH_THRESHOLD: thr = d;
				default: ;
			endcase
		endfunction

		function logic [63:0] mag(longint v);
			return v < 0 ? -v : v;
		endfunction

		// squared distance in Q16 minus target, clamped
		function longint dist_error(longint dx, longint dy, logic [fvl_pkg::TGT_W-1:0] t);
			longint s;
			s = ((dx * dx + dy * dy) >> 16) - longint'({32'd0, t});
			if (s > 64'sd34359738367) s = 64'sd34359738367;
			if (s < -64'sd34359738367) s = -64'sd34359738367;
			return s;
		endfunction

		// -(k / 2^sh) * n / det, saturated to 24 bits
		function logic [fvl_pkg::VEL_W-1:0] vel_component(longint n, longint det,
			logic [fvl_pkg::GAIN_W-1:0] k, int sh);
			logic [127:0] x, q, lim;
			bit neg;
			if (n == 0 || k == 0) return '0;
			neg = (n < 0) == (det < 0);
			if (det == 0) neg = n > 0;
			lim = neg ? 128'h800000 : 128'h7fffff;
			if (det == 0) begin
				q = lim;
			end else begin
				x = {64'd0, mag(n)};
				x = (x * k) >> sh;
				q = x / {64'd0, mag(det)};
				if (q > lim) q = lim;
			end
			return neg ? -q[fvl_pkg::VEL_W-1:0] : q[fvl_pkg::VEL_W-1:0];
		endfunction

		function void follower(longint r1x, longint r1y, longint r2x, longint r2y,
			longint b0, longint b1, logic [fvl_pkg::GAIN_W-1:0] k, int bound,
			output logic [fvl_pkg::VEL_W-1:0] vx, output logic [fvl_pkg::VEL_W-1:0] vy,
			output logic sing);
			longint det, n0, n1;
			logic [127:0] prod;
			det  = r1x * r2y - r1y * r2x;
			n0   = r2y * b0 - r1y * b1;
			n1   = r1x * b1 - r2x * b0;
			prod = {64'd0, mag(det)} * bound;
			sing = prod < (128'd1 << 32);
			vx   = vel_component(n0, det, k, 1);
			vy   = vel_component(n1, det, k, 2);
		endfunction

		function void note_request(logic signed [fvl_pkg::POS_W-1:0] p2x, p2y, p3x, p3y);
			longint x2, y2, x3, y3, ax, ay, e12, e13, e23;
			logic [63:0] m;
			logic [fvl_pkg::GAIN_W-1:0] k;
			vel_rec_t r;
			x2 = p2x; y2 = p2y; x3 = p3x; y3 = p3y; ax = anc_x; ay = anc_y;
			e12 = dist_error(ax - x2, ay - y2, tgt12);
			e13 = dist_error(ax - x3, ay - y3, tgt13);
			e23 = dist_error(x2 - x3, y2 - y3, tgt23);
			m = mag(e12);
			if (mag(e13) < m) m = mag(e13);
			if (mag(e23) < m) m = mag(e23);
			r.near = m < {32'd0, thr};
			k = r.near ? k_near : k_far;
			follower(x2 - ax, y2 - ay, x2 - x3, y2 - y3, e12, e23, k,
				fvl_pkg::SING2_BOUND, r.vel2_x, r.vel2_y, r.sing2);
			follower(x3 - ax, y3 - ay, x3 - x2, y3 - y2, e13, e23, k,
				fvl_pkg::SING3_BOUND, r.vel3_x, r.vel3_y, r.sing3);
			pending.push_back(r);
		endfunction

		function void check_result(vel_rec_t a);
			vel_rec_t e;
			if (pending.size() == 0) begin
				$error("velocity result with no request outstanding");
				fails++;
				return;
			end
			e = pending.pop_front();
			if (a.vel2_x !== e.vel2_x) begin
				$error("vel2_x expected %0d got %0d", e.vel2_x, a.vel2_x); fails++;
			end
			if (a.vel2_y !== e.vel2_y) begin
				$error("vel2_y expected %0d got %0d", e.vel2_y, a.vel2_y); fails++;
			end
			if (a.vel3_x !== e.vel3_x) begin
				$error("vel3_x expected %0d got %0d", e.vel3_x, a.vel3_x); fails++;
			end
			if (a.vel3_y !== e.vel3_y) begin
				$error("vel3_y expected %0d got %0d", e.vel3_y, a.vel3_y); fails++;
			end
			if (a.near !== e.near) begin
				$error("near_gain_used expected %0d got %0d", e.near, a.near); fails++;
			end
			if (a.sing2 !== e.sing2) begin
				$error("singular2 expected %0d got %0d", e.sing2, a.sing2); fails++;
			end
			if (a.sing3 !== e.sing3) begin
				$error("singular3 expected %0d got %0d", e.sing3, a.sing3); fails++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	bit   hold_req = 0;
	int   hold_left = 0;
	int   cycle_cnt = 0;
	formation_scoreboard sb = new();

	fvl_pos_if pos();
	fvl_vel_if vel();
	fvl_cfg_if cfg();

	formation_velocity_law_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.pos(pos),
		.vel(vel),
		.cfg(cfg)
	);

	always #2ns clk = ~clk;

	initial begin
		pos.valid = 0; pos.pos2_x = 0; pos.pos2_y = 0; pos.pos3_x = 0; pos.pos3_y = 0;
		cfg.valid = 0; cfg.index = 0; cfg.data = 0;
		vel.ready = 0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > 600000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver: random stalls plus a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 0;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			vel.ready <= 1'b0;
		end else begin
			vel.ready <= $urandom_range(99) >= recv_stall_pct;
		end
	end

	// accepted requests and results
	always @(posedge clk) begin
		vel_rec_t a;
		if (arst_n && pos.valid && pos.ready)
			sb.note_request(pos.pos2_x, pos.pos2_y, pos.pos3_x, pos.pos3_y);
		if (arst_n && vel.valid && vel.ready) begin
			a.vel2_x = vel.vel2_x; a.vel2_y = vel.vel2_y;
			a.vel3_x = vel.vel3_x; a.vel3_y = vel.vel3_y;
			a.near = vel.near_gain_used; a.sing2 = vel.singular2; a.sing3 = vel.singular3;
			sb.check_result(a);
		end
	end

	task automatic write_reg(fvl_pkg::cfg_idx_t idx, logic [fvl_pkg::CFG_DATA_W-1:0] d);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= d;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		sb.write_reg(idx, d);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_request(logic [fvl_pkg::POS_W-1:0] p2x, p2y, p3x, p3y);
		while ($urandom_range(99) < send_idle_pct) begin
			pos.valid <= 1'b0;
			@(posedge clk);
		end
		pos.valid  <= 1'b1;
		pos.pos2_x <= p2x;
		pos.pos2_y <= p2y;
		pos.pos3_x <= p3x;
		pos.pos3_y <= p3y;
		@(posedge clk);
		while (!pos.ready) @(posedge clk);
	endtask

	// wait until every predicted result has arrived, then let the pipe drain
	task automatic drain();
		pos.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// follower offset around the leader: mostly near formation, some far
	function automatic logic [fvl_pkg::POS_W-1:0] around(logic [fvl_pkg::POS_W-1:0] base);
		int r;
		r = $urandom_range(99);
		if (r < 60) return fvl_pkg::POS_W'(base + $urandom_range(0, 393216) - 196608);
		if (r < 85) return fvl_pkg::POS_W'(base + $urandom_range(0, 1048576) - 524288);
		return fvl_pkg::POS_W'($urandom);
	endfunction

	task automatic random_requests(int n);
		logic [fvl_pkg::POS_W-1:0] p2x, p2y, p3x, p3y;
		repeat (n) begin
			p2x = around(sb.anc_x);
			p2y = around(sb.anc_y);
			p3x = around(sb.anc_x);
			p3y = around(sb.anc_y);
			// sometimes collinear or coincident followers for tiny determinants
			case ($urandom_range(9))
				0: begin p3x = p2x; p3y = p2y; end
				1: begin p2x = sb.anc_x; p2y = sb.anc_y; end
				2: begin p3x = p2x + (p2x - sb.anc_x); p3y = p2y + (p2y - sb.anc_y); end
				3: begin p3x = p2x + $urandom_range(2); p3y = p2y; end
				default: ;
			endcase
			send_request(p2x, p2y, p3x, p3y);
		end
	endtask

	task automatic load_regs(logic [31:0] ax, ay, t12, t13, t23, kn, kf, th);
		write_reg(fvl_pkg::CFG_ANCHOR_X, ax);
		write_reg(fvl_pkg::CFG_ANCHOR_Y, ay);
		write_reg(fvl_pkg::CFG_TARGET_SQ_12, t12);
		write_reg(fvl_pkg::CFG_TARGET_SQ_13, t13);
		write_reg(fvl_pkg::CFG_TARGET_SQ_23, t23);
		write_reg(fvl_pkg::CFG_GAIN_NEAR, kn);
		write_reg(fvl_pkg::CFG_GAIN_FAR, kf);
		write_reg(fvl_pkg::CFG_SWITCH_THRESHOLD, th);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, coincident and collinear followers, on formation
		send_request(0, 0, 0, 0);
		send_request(24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000);
		send_request(24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff);
		send_request(24'h7fffff, 24'h800000, 24'h800000, 24'h7fffff);
		send_request(sb.anc_x, sb.anc_y, 24'h10000, 24'h10000);
		send_request(24'h10000, 24'h10000, sb.anc_x, sb.anc_y);
		send_request(24'h20000, 24'h30000, 24'h20000, 24'h30000);
		send_request(sb.anc_x, sb.anc_y, sb.anc_x, sb.anc_y);
		send_request(-24'sd65536, 24'h40000, -24'sd327680, 24'h40000);
		send_request(-24'sd196608, 24'h60000, -24'sd196608, 24'h20000);
		send_request(-24'sd196608 + 24'sd113512, 24'h60000, -24'sd196608 - 24'sd113512,
			24'h60000);
		send_request(-24'sd65536, 24'h40000, -24'sd65535, 24'h40001);
		send_request(24'h000001, 24'hffffff, 24'hffffff, 24'h000001);
		send_request(24'h555555, 24'haaaaaa, 24'h333333, 24'hcccccc);
		send_request(24'haaaaaa, 24'h555555, 24'hcccccc, 24'h333333);
		random_requests(230);
		drain();

		// maximum registers, sender idling
		send_idle_pct = 55;
		load_regs(32'h7fffff, 32'h7fffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
			32'hffff, 32'hffff, 32'hffffffff);
		random_requests(250);
		drain();

		// minimum registers, receiver stalling
		send_idle_pct = 0;
		recv_stall_pct = 55;
		load_regs(32'h800000, 32'h800000, 0, 0, 0, 0, 0, 0);
		random_requests(250);
		drain();

		// random realistic registers, both sides idling
		send_idle_pct = 34;
		recv_stall_pct = 34;
		load_regs($urandom_range(0, 2097152) - 1048576, $urandom_range(0, 2097152) - 1048576,
			$urandom_range(0, 1048576), $urandom_range(0, 1048576),
			$urandom_range(0, 2097152), $urandom_range(0, 65535),
			$urandom_range(0, 65535), $urandom_range(0, 1048576));
		random_requests(250);
		drain();

		// defaults again, no idling, with a long receiver hold-off
		send_idle_pct = 0;
		recv_stall_pct = 0;
		load_regs(-32'sd196608, 262144, 262144, 262144, 786432, 655, 2621, 327680);
		hold_req = 1;
		random_requests(250);
		drain();

		if (sb.fails == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
